>>> rtl/core/oldq_pkg.sv
// shared types, codes and defaults for the ordered list deque engine
package oldq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // command codes
   localparam logic [2:0] CMD_PUSH_FRONT   = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK    = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT    = 3'd2;
   localparam logic [2:0] CMD_POP_BACK     = 3'd3;
   localparam logic [2:0] CMD_REMOVE_VALUE = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_EMPTY    = 2'd1;
   localparam logic [1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [1:0] STAT_FULL     = 2'd3;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] data_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] removed_value;
      logic [4:0]         entry_count;
      logic               list_empty;
   } rsp_type;

endpackage

>>> rtl/core/ordered_list_deque_engine.sv
// ordered list deque engine: ring-buffer deque with delete by value
//
// usage
//   req channel carries one command per transfer (cmd, data_value); rsp channel
//   returns exactly one result per command, in order (status, removed_value,
//   entry_count, list_empty). both channels use valid/stall handshakes.
// path from accept to the result register
//   inserts and rejected commands: done
//   remove front / remove back: read, done
//   remove by value: scan over the entries, shift if found, then done
// throughput
//   one command at a time; the next command is taken once the current one has
//   moved into the result register. the single read port of the entry memory
//   sets the pace: the value search reads one entry per cycle and the gap
//   close reads and writes back one entry per cycle
// reset
//   synchronous reset empties the list (head and count cleared) and drops any
//   pending result; memory contents are left as they are
// back pressure
//   a result waiting under rsp_stall holds; a new command is still accepted,
//   and its result waits in the done state until the output register frees
module ordered_list_deque_engine #(
   parameter int DEPTH      = oldq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = oldq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  oldq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output oldq_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);      // ring index width
   localparam int CW = $clog2(DEPTH + 1);  // count width, holds DEPTH itself
   localparam int SW = AW + 1;             // head plus offset before wrap

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_SHIFT = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // ring position of the entry at a given offset from the front
   function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
      logic [SW-1:0] s;
      s = SW'(base) + SW'(off);
      if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
      return s[AW-1:0];
   endfunction

   // sign extend a stored entry and keep the low 32 bits for the result
   function automatic logic [31:0] widen(input logic [DATA_WIDTH-1:0] v);
      logic [63:0] e;
      e = 64'($signed(v));
      return e[31:0];
   endfunction

   // entry memory, one write and one registered read per cycle
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic                  mem_re;
   logic [AW-1:0]         mem_ra;
   logic                  mem_we;
   logic [AW-1:0]         mem_wa;
   logic [DATA_WIDTH-1:0] mem_wd;
   logic [DATA_WIDTH-1:0] mem_rd_ff;

   // control and working registers
   state_type             state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [1:0]            st_ff, st_in;
   logic [31:0]           rem_ff, rem_in;
   logic [CW-1:0]         idx_ff, idx_in;      // next offset to read
   logic [CW-1:0]         idx_d_ff, idx_d_in;  // offset of the read now returning
   logic                  pipe_ff, pipe_in;    // a read is returning this cycle
   logic                  rsp_valid_ff, rsp_valid_in;
   oldq_pkg::rsp_type     rsp_ff, rsp_in;

   logic [DATA_WIDTH-1:0] req_val;
   logic [AW-1:0]         head_dec;
   logic                  list_full;
   logic                  list_none;

   // only the low DATA_WIDTH bits of the value take part
   assign req_val   = DATA_WIDTH'($unsigned(req_data.data_value));
   assign head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign list_full = (cnt_ff == CW'(DEPTH));
   assign list_none = (cnt_ff == '0);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      val_in       = val_ff;
      st_in        = st_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      idx_d_in     = idx_d_ff;
      pipe_in      = pipe_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_re       = 1'b0;
      mem_ra       = '0;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = req_val;

      // result taken downstream
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in   = req_val;
               st_in    = oldq_pkg::STAT_OK;
               rem_in   = '0;
               state_in = ST_DONE;
               unique case (req_data.cmd)
                  oldq_pkg::CMD_PUSH_FRONT: begin
                     if (list_full) begin
                        st_in = oldq_pkg::STAT_FULL;
                     end else begin
                        head_in = head_dec;
                        mem_we  = 1'b1;
                        mem_wa  = head_dec;
                        cnt_in  = cnt_ff + CW'(1);
                     end
                  end
                  oldq_pkg::CMD_PUSH_BACK: begin
                     if (list_full) begin
                        st_in = oldq_pkg::STAT_FULL;
                     end else begin
                        mem_we = 1'b1;
                        mem_wa = ring_slot(head_ff, cnt_ff);
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  oldq_pkg::CMD_POP_FRONT: begin
                     if (list_none) begin
                        st_in = oldq_pkg::STAT_EMPTY;
                     end else begin
                        mem_re   = 1'b1;
                        mem_ra   = head_ff;
                        head_in  = ring_slot(head_ff, CW'(1));
                        cnt_in   = cnt_ff - CW'(1);
                        state_in = ST_READ;
                     end
                  end
                  oldq_pkg::CMD_POP_BACK: begin
                     if (list_none) begin
                        st_in = oldq_pkg::STAT_EMPTY;
                     end else begin
                        mem_re   = 1'b1;
                        mem_ra   = ring_slot(head_ff, cnt_ff - CW'(1));
                        cnt_in   = cnt_ff - CW'(1);
                        state_in = ST_READ;
                     end
                  end
                  oldq_pkg::CMD_REMOVE_VALUE: begin
                     if (list_none) begin
                        st_in = oldq_pkg::STAT_EMPTY;
                     end else begin
                        idx_in   = '0;
                        pipe_in  = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;  // unused codes answer ok and change nothing
               endcase
            end
         end

         ST_READ: begin
            rem_in   = widen(mem_rd_ff);
            state_in = ST_DONE;
         end

         ST_SCAN: begin
            // keep one read in flight while the previous one is compared
            if (idx_ff < cnt_ff) begin
               mem_re   = 1'b1;
               mem_ra   = ring_slot(head_ff, idx_ff);
               idx_in   = idx_ff + CW'(1);
               idx_d_in = idx_ff;
               pipe_in  = 1'b1;
            end else begin
               pipe_in = 1'b0;
            end
            if (pipe_ff) begin
               if (mem_rd_ff == val_ff) begin
                  // first match from the front: close the gap behind it
                  rem_in   = widen(mem_rd_ff);
                  idx_in   = idx_d_ff + CW'(1);
                  pipe_in  = 1'b0;
                  state_in = ST_SHIFT;
               end else if (idx_d_ff == cnt_ff - CW'(1)) begin
                  st_in    = oldq_pkg::STAT_NOTFOUND;
                  pipe_in  = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end

         ST_SHIFT: begin
            // write back the entry read last cycle one place toward the front
            if (pipe_ff) begin
               mem_we = 1'b1;
               mem_wa = ring_slot(head_ff, idx_d_ff);
               mem_wd = mem_rd_ff;
            end
            if (idx_ff < cnt_ff) begin
               mem_re   = 1'b1;
               mem_ra   = ring_slot(head_ff, idx_ff);
               idx_d_in = idx_ff - CW'(1);
               idx_in   = idx_ff + CW'(1);
               pipe_in  = 1'b1;
            end else begin
               // tail follows since the count drops by one
               pipe_in  = 1'b0;
               cnt_in   = cnt_ff - CW'(1);
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = st_ff;
               rsp_in.removed_value = rem_ff;
               rsp_in.entry_count   = 5'(cnt_ff);
               rsp_in.list_empty    = list_none;
               state_in             = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         cnt_ff       <= '0;
         pipe_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         pipe_ff      <= pipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers, no reset needed
   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      st_ff    <= st_in;
      rem_ff   <= rem_in;
      idx_ff   <= idx_in;
      idx_d_ff <= idx_d_in;
      rsp_ff   <= rsp_in;
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) mem_rd_ff <= mem[mem_ra];
   end

endmodule

>>> rtl/core/oldq_checker.sv
// port-level assertions for the ordered list deque engine, bound to the top level
module oldq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input oldq_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input oldq_pkg::rsp_type rsp_data
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a full answer means the list still holds entries
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == oldq_pkg::STAT_FULL |-> !rsp_data.list_empty)
      else $error("full status with empty list");

   // an empty answer leaves the list empty and removes nothing
   a_empty_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == oldq_pkg::STAT_EMPTY
      |-> rsp_data.list_empty && rsp_data.removed_value == '0
          && rsp_data.entry_count == '0)
      else $error("empty status inconsistent");

   // a failed search removes nothing and leaves entries in place
   a_notfound_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == oldq_pkg::STAT_NOTFOUND
      |-> rsp_data.removed_value == '0 && !rsp_data.list_empty)
      else $error("not-found status inconsistent");

endmodule

bind ordered_list_deque_engine oldq_checker u_oldq_checker (.*);
